/* hdl/ple_pkg.sv */
// ----------------------------------------------------------------------------
// ple_pkg
// Shared opcodes, status codes and controller interface types of the list
// engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int OpW = 3;
  localparam int StW = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_REMOVE_AT  = 3'd5,
    OP_SWAP       = 3'd6,
    OP_SET_MARKER = 3'd7
  } op_t;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // What the datapath does with the cell array.
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_SWAP   = 3'd3,
    ACT_SET    = 3'd4
  } act_t;

  // Controller to datapath.
  typedef struct packed {
    logic    exec;     // apply the operation of the held item
    act_t    act;
    status_t status;
  } ple_cmd_t;

endpackage

/* hdl/positional_list_engine.sv */
// ----------------------------------------------------------------------------
// positional_list_engine
// Packed list with push/pop at both ends, positional insert/remove, swap and
// set-marker. Results carry status, count and the removed word.
// ----------------------------------------------------------------------------
// The result of an accepted item is loaded into the output register as it is taken.
// Throughput: one item per cycle unless the receiver stalls a full result register;
// the cell row shifts every entry at once. A new item is taken while the result register drains in the same cycle.
// Reset (rst, synchronous): cells and count clear, marker reloads to 18,
// the result register empties. No clearing pass is needed.
module positional_list_engine import ple_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] value,
  input  logic [5:0]  index_a,
  input  logic [5:0]  index_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [6:0]  count,
  output logic [31:0] removed_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int IW = 6;
  localparam int CW = $clog2(DEPTH + 1);

  ple_cmd_t         cmd;
  logic             in_take, load_res;
  logic [CW-1:0]    entry_count;
  logic [CW-1:0]    ia, ib;
  logic [WIDTH-1:0] wval;
  logic [CW-1:0]    res_count;
  status_t          res_status;

  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign wval      = WIDTH'(value);

  // Map front/back ends onto positions for the shared insert/remove path.
  always_comb begin
    ia = CW'(index_a);
    ib = CW'(index_b);
    unique case (op_t'(opcode))
      OP_PUSH_BACK:  ia = entry_count;
      OP_PUSH_FRONT: ia = '0;
      OP_POP_BACK:   ia = entry_count - CW'(1);
      OP_POP_FRONT:  ia = '0;
      default: ;
    endcase
  end

  ple_ctrl #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_ctrl (
    .clk, .rst, .in_take, .opcode,
    .index_a(index_a), .index_b(index_b),
    .entry_count, .out_stall, .cmd, .load_res, .out_valid, .in_stall
  );

  ple_datapath #(.DEPTH(DEPTH), .WIDTH(WIDTH), .IW(CW), .CW(CW)) u_dp (
    .clk, .rst, .cmd, .value(wval), .index_a(ia), .index_b(ib),
    .marker_in(cfg_data), .marker_we(cfg_valid), .load_res, .entry_count,
    .res_status, .res_count(res_count), .res_removed(removed_value)
  );

  assign status = res_status;
  assign count  = 7'(res_count);

endmodule

/* hdl/ple_datapath.sv */
// ----------------------------------------------------------------------------
// ple_datapath
// Row of list cells with a shift-by-one in either direction, swap and set,
// plus the entry count, marker register and result register.
// ----------------------------------------------------------------------------
module ple_datapath import ple_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  ple_cmd_t         cmd,
  input  logic [WIDTH-1:0] value,
  input  logic [IW-1:0]    index_a,
  input  logic [IW-1:0]    index_b,
  input  logic [31:0]      marker_in,
  input  logic             marker_we,
  input  logic             load_res,
  output logic [CW-1:0]    entry_count,
  output status_t          res_status,
  output logic [CW-1:0]    res_count,
  output logic [31:0]      res_removed
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] cells [DEPTH];
  logic [31:0]      marker;
  logic [CW-1:0]    pos_full;
  logic [PW-1:0]    pos;
  logic [PW-1:0]    pb;
  logic [WIDTH-1:0] removed_w;
  logic [31:0]      removed_ext;

  // Position that the operation acts on: index_a, truncated to the cell index width.
  assign pos_full = (cmd.act == ACT_REMOVE || cmd.act == ACT_INSERT ||
                     cmd.act == ACT_SWAP || cmd.act == ACT_SET)
                    ? CW'(index_a) : '0;
  assign pos = pos_full[PW-1:0];
  assign pb  = PW'(index_b);
  assign removed_w = cells[pos];

  always_comb begin
    removed_ext = '0;
    removed_ext[((WIDTH < 32) ? WIDTH : 32)-1:0] =
      removed_w[((WIDTH < 32) ? WIDTH : 32)-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= 32'd18;
    end else if (marker_we) begin
      marker <= marker_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.exec && cmd.act == ACT_INSERT) begin
      entry_count <= entry_count + CW'(1);
    end else if (cmd.exec && cmd.act == ACT_REMOVE) begin
      entry_count <= entry_count - CW'(1);
    end
  end

  // For shifts each cell looks at itself and its two neighbors; swap reads both positions.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (rst) begin
        cells[i] <= '0;
      end else if (cmd.exec) begin
        case (cmd.act)
          ACT_INSERT: begin
            if (PW'(i) == pos) cells[i] <= value;
            else if (PW'(i) > pos && i > 0) cells[i] <= cells[(i > 0) ? i-1 : 0];
          end
          ACT_REMOVE: begin
            if (PW'(i) >= pos) begin
              if (i == DEPTH-1 || CW'(i+1) >= entry_count) cells[i] <= '0;
              else cells[i] <= cells[(i < DEPTH-1) ? i+1 : i];
            end
          end
          ACT_SWAP: begin
            if (PW'(i) == pos) cells[i] <= cells[pb];
            else if (PW'(i) == pb) cells[i] <= cells[pos];
          end
          ACT_SET: begin
            if (PW'(i) == pos) cells[i] <= WIDTH'(marker);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_status  <= cmd.status;
      res_count   <= entry_count;
      res_removed <= '0;
      if (cmd.exec && cmd.act == ACT_INSERT) res_count <= entry_count + CW'(1);
      if (cmd.exec && cmd.act == ACT_REMOVE) begin
        res_count   <= entry_count - CW'(1);
        res_removed <= removed_ext;
      end
    end
  end

endmodule

/* hdl/ple_ctrl.sv */
// ----------------------------------------------------------------------------
// ple_ctrl
// Decodes the opcode against the count, checks ranges and runs the result
// register handshake.
// ----------------------------------------------------------------------------
module ple_ctrl import ple_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IW    = 6,
  parameter int CW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_take,
  input  logic [OpW-1:0] opcode,
  input  logic [IW-1:0] index_a,
  input  logic [IW-1:0] index_b,
  input  logic [CW-1:0] entry_count,
  input  logic          out_stall,
  output ple_cmd_t      cmd,
  output logic          load_res,
  output logic          out_valid,
  output logic          in_stall
);

  localparam int XW = (IW > CW) ? IW : CW;

  typedef enum logic [1:0] {
    S_EMPTY = 2'b01,
    S_FULL  = 2'b10
  } state_t;

  state_t state, state_next;
  logic   full, empty, a_in, b_in, a_ins;

  assign full  = entry_count >= CW'(DEPTH);
  assign empty = entry_count == '0;
  assign a_in  = XW'(index_a) < XW'(entry_count);
  assign b_in  = XW'(index_b) < XW'(entry_count);
  assign a_ins = XW'(index_a) <= XW'(entry_count);

  // One result register: accept when it is empty or being drained.
  assign in_stall = (state == S_FULL) && out_stall;
  assign out_valid = (state == S_FULL);
  assign load_res = in_take;

  always_comb begin
    cmd.act    = ACT_NONE;
    cmd.status = ST_OK;
    unique case (op_t'(opcode))
      OP_PUSH_BACK: begin
        if (full) cmd.status = ST_FULL;
        else cmd.act = ACT_INSERT;
      end
      OP_PUSH_FRONT: begin
        if (full) cmd.status = ST_FULL;
        else cmd.act = ACT_INSERT;
      end
      OP_INSERT_AT: begin
        if (full) cmd.status = ST_FULL;
        else if (!a_ins) cmd.status = ST_RANGE;
        else cmd.act = ACT_INSERT;
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (empty) cmd.status = ST_EMPTY;
        else cmd.act = ACT_REMOVE;
      end
      OP_REMOVE_AT: begin
        if (empty) cmd.status = ST_EMPTY;
        else if (!a_in) cmd.status = ST_RANGE;
        else cmd.act = ACT_REMOVE;
      end
      OP_SWAP: begin
        if (!a_in || !b_in) cmd.status = ST_RANGE;
        else cmd.act = ACT_SWAP;
      end
      OP_SET_MARKER: begin
        if (!a_in) cmd.status = ST_RANGE;
        else cmd.act = ACT_SET;
      end
      default: ;
    endcase
    cmd.exec = in_take && (cmd.act != ACT_NONE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_EMPTY: if (in_take) state_next = S_FULL;
      S_FULL:  if (!out_stall && !in_take) state_next = S_EMPTY;
      default: state_next = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_EMPTY;
    else     state <= state_next;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH)) else $error("count above depth");
  a_no_grow_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !(cmd.exec && cmd.act == ACT_INSERT)) else $error("insert when full");
  a_no_shrink_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !(cmd.exec && cmd.act == ACT_REMOVE)) else $error("remove when empty");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    in_take |=> out_valid) else $error("result lost");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine. A scoreboard class keeps
// its own copy of the list and the marker, predicts status, count and removed
// word for every accepted item, and compares each result in order. Directed
// corner items come first, then random traffic with random idling on both
// sides, a long receiver hold-off and a drain pause, across marker settings.
// ----------------------------------------------------------------------------
module tb_top;
  import ple_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 64;

  typedef struct packed {
    status_t     st;
    logic [6:0]  cnt;
    logic [31:0] removed;
  } list_result_t;

  class list_scoreboard;
    logic [31:0]  words[Depth];
    int           fill;
    logic [31:0]  marker;
    list_result_t pending[$];
    int           errors;

    function void clear();
      foreach (words[i]) words[i] = '0;
      fill = 0;
      marker = 32'd18;
      pending.delete();
      errors = 0;
    endfunction

    function logic [31:0] take(int pos);
      logic [31:0] w;
      w = words[pos];
      for (int i = pos; i + 1 < fill; i++) words[i] = words[i + 1];
      words[fill - 1] = '0;
      fill--;
      return w;
    endfunction

    function void put(int pos, logic [31:0] w);
      for (int i = fill; i > pos; i--) words[i] = words[i - 1];
      words[pos] = w;
      fill++;
    endfunction

    function void note_item(op_t op, logic [31:0] v, int ia, int ib);
      list_result_t r;
      logic [31:0] t;
      r.st = ST_OK;
      r.removed = '0;
      case (op)
        OP_PUSH_BACK:  if (fill >= Depth) r.st = ST_FULL; else put(fill, v);
        OP_PUSH_FRONT: if (fill >= Depth) r.st = ST_FULL; else put(0, v);
        OP_INSERT_AT: begin
          if (fill >= Depth) r.st = ST_FULL;
          else if (ia > fill) r.st = ST_RANGE;
          else put(ia, v);
        end
        OP_POP_BACK:  if (fill == 0) r.st = ST_EMPTY; else r.removed = take(fill - 1);
        OP_POP_FRONT: if (fill == 0) r.st = ST_EMPTY; else r.removed = take(0);
        OP_REMOVE_AT: begin
          if (fill == 0) r.st = ST_EMPTY;
          else if (ia >= fill) r.st = ST_RANGE;
          else r.removed = take(ia);
        end
        OP_SWAP: begin
          if (ia >= fill || ib >= fill) r.st = ST_RANGE;
          else begin
            t = words[ia];
            words[ia] = words[ib];
            words[ib] = t;
          end
        end
        default: if (ia >= fill) r.st = ST_RANGE; else words[ia] = marker;
      endcase
      r.cnt = 7'(fill);
      pending = {pending, r};
    endfunction

    function void check_result(logic [1:0] st, logic [6:0] cnt, logic [31:0] rm);
      list_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result st=%0d cnt=%0d rm=%h", $time, st, cnt, rm);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
      if (cnt !== e.cnt) begin
        $display("%0t: count expected %0d actual %0d", $time, e.cnt, cnt);
        errors++;
      end
      if (rm !== e.removed) begin
        $display("%0t: removed expected %h actual %h", $time, e.removed, rm);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  opcode = '0;
  logic [31:0] value = '0;
  logic [5:0]  index_a = '0;
  logic [5:0]  index_b = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic [6:0]  count;
  logic [31:0] removed_value;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  list_scoreboard sb;
  int  idle_pct = 18;
  int  hold_cycles = 0;
  longint cycles = 0;

  positional_list_engine dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Check results and count cycles at the rising edge.
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, count, removed_value);
    if (cycles > 400000) begin
      $display("[positional_list_engine] ERROR");
      $finish;
    end
  end

  // Receiver: random stall, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Hold valid between back-to-back items; drop it only while idling.
  task automatic send(op_t op, logic [31:0] v, int ia, int ib);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    value <= v;
    index_a <= 6'(ia);
    index_b <= 6'(ib);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, v, ia, ib);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_marker(logic [31:0] m);
    drain();
    cfg_valid <= 1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.marker = m;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Index mostly near the valid range, sometimes anywhere.
  function automatic int pick_index(int fill);
    if ($urandom_range(9) == 0) return $urandom_range(63);
    return $urandom_range(fill < 63 ? fill : 63);
  endfunction

  task automatic random_items(int n, int bias);
    op_t op;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      // Bias toward growth or shrink so the list sweeps full and empty.
      if (r < bias) op = op_t'($urandom_range(2));
      else if (r < 80) op = op_t'(3 + $urandom_range(2));
      else op = op_t'($urandom_range(7));
      send(op, $urandom, pick_index(sb.fill), pick_index(sb.fill));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: empty list, then corners, then fill to full and corners at full.
    send(OP_POP_BACK, 0, 0, 0);
    send(OP_POP_FRONT, 0, 0, 0);
    send(OP_REMOVE_AT, 0, 0, 0);
    send(OP_SWAP, 0, 0, 0);
    send(OP_SET_MARKER, 0, 0, 0);
    send(OP_INSERT_AT, 32'hFFFF_FFFF, 1, 0);
    send(OP_INSERT_AT, 32'hFFFF_FFFF, 0, 0);
    send(OP_PUSH_FRONT, 32'h0, 0, 0);
    send(OP_PUSH_BACK, 32'hA5A5_5A5A, 0, 0);
    send(OP_INSERT_AT, 32'h1234_5678, 3, 0);
    send(OP_SWAP, 0, 0, 3);
    send(OP_SWAP, 0, 2, 2);
    send(OP_SWAP, 0, 1, 63);
    send(OP_SET_MARKER, 0, 1, 0);
    send(OP_SET_MARKER, 0, 63, 0);
    send(OP_REMOVE_AT, 0, 1, 0);
    send(OP_REMOVE_AT, 0, 63, 0);
    send(OP_POP_FRONT, 0, 0, 0);
    send(OP_POP_BACK, 0, 0, 0);
    while (sb.fill < Depth) send(OP_PUSH_BACK, $urandom, 0, 0);
    send(OP_PUSH_BACK, 1, 0, 0);
    send(OP_PUSH_FRONT, 2, 0, 0);
    send(OP_INSERT_AT, 3, 63, 0);
    send(OP_SWAP, 0, 63, 0);
    send(OP_REMOVE_AT, 0, 63, 0);
    write_marker(32'hFFFF_FFFF);
    send(OP_SET_MARKER, 0, 5, 0);

    // Long stretch with no idling.
    idle_pct = 0;
    random_items(300, 40);
    idle_pct = 18;
    write_marker(32'h0);
    random_items(400, 60);

    // Receiver holds off while the sender keeps offering items.
    hold_cycles = 60;
    random_items(100, 50);
    drain();
    write_marker($urandom);
    random_items(400, 30);
    write_marker(32'd18);
    random_items(400, 50);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[positional_list_engine] OK");
    else
      $display("[positional_list_engine] ERROR");
    $finish;
  end
endmodule
